@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the checker files of the project.
// Every macro samples on the rising edge of i_clk in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("port check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("port check failed");

// Next-cycle implication that stays active during reset.
`define CHK_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("reset check failed");

`endif

@@ hw/rtl/glw_pkg.sv @@
// Shared types and fixed widths of the weighted Laplacian stencil.
// No dependencies; every other RTL file but assert_macros.svh imports this package.
`timescale 1ns / 1ps

package glw_pkg;

    localparam int POT_W   = 16;  // potential and charge, signed Q8.8
    localparam int SUM_W   = 19;  // sum of four differences, signed
    localparam int FORCE_W = 34;  // exact Q18.16 product
    localparam int IDX_W   = 7;   // reported cell index

    // Control for one shift of the line buffer and the stencil it produces.
    typedef struct packed {
        logic              shift;
        logic              emit;
        logic              has_up;
        logic              has_down;
        logic              has_left;
        logic              has_right;
        logic              last;
        logic [IDX_W-1:0]  idx;
    } t_ctl;

    // Neighborhood taps of the cell that moves into the center position.
    typedef struct packed {
        logic signed [POT_W-1:0] self_p;
        logic signed [POT_W-1:0] up_p;
        logic signed [POT_W-1:0] left_p;
        logic signed [POT_W-1:0] right_p;
        logic signed [POT_W-1:0] chg;
    } t_taps;

endpackage

@@ hw/rtl/glw_ctrl.sv @@
// Sequencing of the stencil: grid position, end-of-grid flush and edge flags.
// Depends on glw_pkg.
`timescale 1ns / 1ps

module glw_ctrl #(
    parameter int WIDTH  = 9,
    parameter int HEIGHT = 9
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    input  logic          i_adv,
    output logic          o_in_ready,
    output glw_pkg::t_ctl o_ctl
);
    import glw_pkg::*;

    localparam int CELLS = WIDTH * HEIGHT;
    localparam int CLW   = $clog2(WIDTH);
    localparam int RWW   = $clog2(HEIGHT);
    localparam int CW    = $clog2(CELLS);
    localparam int IXW   = CW + IDX_W;

    logic [CLW-1:0] r_col, n_col;
    logic [RWW-1:0] r_row, n_row;
    logic [CLW-1:0] r_fl_col, n_fl_col;
    logic           r_flush, n_flush;
    logic [CW-1:0]  r_eidx, n_eidx;

    logic           accept;
    logic           fl_step;
    logic [CLW-1:0] col;
    logic [IXW-1:0] idx_wide;

    always_comb begin
        o_in_ready = !r_flush && i_adv;
        accept     = i_in_valid && o_in_ready;
        fl_step    = r_flush && i_adv;
        col        = r_flush ? r_fl_col : r_col;
        idx_wide   = IXW'(r_eidx);

        o_ctl.shift     = accept || fl_step;
        o_ctl.emit      = (accept && (r_row != '0)) || fl_step;
        o_ctl.has_up    = r_flush || (r_row > RWW'(1));
        o_ctl.has_down  = !r_flush;
        o_ctl.has_left  = (col != '0);
        o_ctl.has_right = (col != CLW'(WIDTH - 1));
        o_ctl.last      = (r_eidx == CW'(CELLS - 1));
        o_ctl.idx       = idx_wide[IDX_W-1:0];

        n_col    = r_col;
        n_row    = r_row;
        n_fl_col = r_fl_col;
        n_flush  = r_flush;
        n_eidx   = r_eidx;

        if (accept) begin
            if (r_col == CLW'(WIDTH - 1)) begin
                n_col = '0;
                if (r_row == RWW'(HEIGHT - 1)) begin
                    // Final cell: the last row is drained by the flush steps.
                    n_row    = '0;
                    n_flush  = 1'b1;
                    n_fl_col = '0;
                end else begin
                    n_row = r_row + RWW'(1);
                end
            end else begin
                n_col = r_col + CLW'(1);
            end
        end

        if (fl_step) begin
            n_fl_col = r_fl_col + CLW'(1);
            if (r_fl_col == CLW'(WIDTH - 1)) begin
                n_flush = 1'b0;
            end
        end

        if (o_ctl.emit) begin
            n_eidx = o_ctl.last ? '0 : r_eidx + CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col    <= '0;
            r_row    <= '0;
            r_fl_col <= '0;
            r_flush  <= 1'b0;
            r_eidx   <= '0;
        end else begin
            r_col    <= n_col;
            r_row    <= n_row;
            r_fl_col <= n_fl_col;
            r_flush  <= n_flush;
            r_eidx   <= n_eidx;
        end
    end

endmodule

@@ hw/rtl/glw_line_buf.sv @@
// Potential line buffer and charge delay line with fixed stencil taps.
// Depends on glw_pkg.
`timescale 1ns / 1ps

module glw_line_buf #(
    parameter int WIDTH = 9
) (
    input  logic                                i_clk,
    input  logic                                i_shift,
    input  logic signed [glw_pkg::POT_W-1:0]    i_potential,
    input  logic signed [glw_pkg::POT_W-1:0]    i_charge,
    output glw_pkg::t_taps                      o_taps
);
    import glw_pkg::*;

    localparam int PDEPTH = 2 * WIDTH;
    localparam int CDEPTH = WIDTH;

    logic signed [POT_W-1:0] r_pot [PDEPTH];
    logic signed [POT_W-1:0] r_chg [CDEPTH];

    // Taps are read before the shift: the entry at WIDTH-1 becomes the center.
    assign o_taps.self_p  = r_pot[WIDTH-1];
    assign o_taps.up_p    = r_pot[2*WIDTH-1];
    assign o_taps.left_p  = r_pot[WIDTH];
    assign o_taps.right_p = r_pot[WIDTH-2];
    assign o_taps.chg     = r_chg[WIDTH-1];

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_pot[0] <= i_potential;
            for (int k = 1; k < PDEPTH; k++) begin
                r_pot[k] <= r_pot[k-1];
            end
            r_chg[0] <= i_charge;
            for (int k = 1; k < CDEPTH; k++) begin
                r_chg[k] <= r_chg[k-1];
            end
        end
    end

endmodule

@@ hw/rtl/glw_stage.sv @@
// Two-stage datapath: neighbor difference sum, then the charge product.
// Depends on glw_pkg.
`timescale 1ns / 1ps

module glw_stage (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  glw_pkg::t_ctl                         i_ctl,
    input  glw_pkg::t_taps                        i_taps,
    input  logic signed [glw_pkg::POT_W-1:0]      i_down,
    input  logic                                  i_out_ready,
    output logic                                  o_adv,
    output logic                                  o_out_valid,
    output logic signed [glw_pkg::FORCE_W-1:0]    o_force_res,
    output logic [glw_pkg::IDX_W-1:0]             o_cell_index,
    output logic                                  o_last
);
    import glw_pkg::*;

    localparam int PW = SUM_W + POT_W;

    logic                    r_s1_vld;
    logic signed [SUM_W-1:0] r_s1_sum, n_s1_sum;
    logic signed [POT_W-1:0] r_s1_chg;
    logic [IDX_W-1:0]        r_s1_idx;
    logic                    r_s1_last;

    logic                      r_s2_vld;
    logic signed [FORCE_W-1:0] r_s2_force;
    logic [IDX_W-1:0]          r_s2_idx;
    logic                      r_s2_last;

    logic                    adv2;
    logic signed [POT_W-1:0] up_v, down_v, left_v, right_v, self_v;
    logic signed [PW-1:0]    prod;

    assign adv2  = !r_s2_vld || i_out_ready;
    assign o_adv = !r_s1_vld || adv2;

    always_comb begin
        self_v  = i_taps.self_p;
        up_v    = i_ctl.has_up    ? i_taps.up_p    : self_v;
        down_v  = i_ctl.has_down  ? i_down         : self_v;
        left_v  = i_ctl.has_left  ? i_taps.left_p  : self_v;
        right_v = i_ctl.has_right ? i_taps.right_p : self_v;
        n_s1_sum = (SUM_W'(up_v) - SUM_W'(self_v)) + (SUM_W'(down_v) - SUM_W'(self_v))
                 + (SUM_W'(left_v) - SUM_W'(self_v)) + (SUM_W'(right_v) - SUM_W'(self_v));
        prod = PW'(r_s1_sum) * PW'(r_s1_chg);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
        end else begin
            if (o_adv) begin
                r_s1_vld <= i_ctl.emit;
            end
            if (adv2) begin
                r_s2_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_adv && i_ctl.emit) begin
            r_s1_sum  <= n_s1_sum;
            r_s1_chg  <= i_taps.chg;
            r_s1_idx  <= i_ctl.idx;
            r_s1_last <= i_ctl.last;
        end
        if (adv2 && r_s1_vld) begin
            r_s2_force <= prod[FORCE_W-1:0];
            r_s2_idx   <= r_s1_idx;
            r_s2_last  <= r_s1_last;
        end
    end

    assign o_out_valid  = r_s2_vld;
    assign o_force_res  = r_s2_force;
    assign o_cell_index = r_s2_idx;
    assign o_last       = r_s2_last;

endmodule

@@ hw/rtl/grid_laplacian_weighted.sv @@
// Weighted five-point Laplacian over a WIDTH by HEIGHT grid.
// Cells arrive on the input channel (i_in_valid / o_in_ready) in row-major
// order, one transfer per cell, carrying a signed Q8.8 potential and charge.
// Each result transfer on the output channel (o_out_valid / i_out_ready)
// carries charge times the sum of the four neighbor differences as an exact
// signed Q18.16 value, the cell's row-major index (low 7 bits) and a flag
// that marks the final cell of the grid. Missing edge neighbors count as the
// cell itself.
// The result for a cell is produced when the cell one row below it arrives
// and passes through the stage-1 and stage-2 registers to the output. The
// block takes one cell per cycle while the output is not stalled. After the
// final cell of a grid it drains the last row, during which o_in_ready stays
// low; the next grid may start right after. The line buffer is a shift
// register of 2*WIDTH potentials, so each neighbor sits at a fixed tap.
// A synchronous reset clears the grid position and the pipeline valid bits.
// When the receiver stalls, the output register holds its result and the
// stall propagates back through the two pipeline stages to o_in_ready.
`timescale 1ns / 1ps

module grid_laplacian_weighted #(
    parameter int WIDTH  = 9,
    parameter int HEIGHT = 9
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_ready,
    input  logic signed [glw_pkg::POT_W-1:0]      i_potential,
    input  logic signed [glw_pkg::POT_W-1:0]      i_charge,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [glw_pkg::FORCE_W-1:0]    o_force_res,
    output logic [glw_pkg::IDX_W-1:0]             o_cell_index,
    output logic                                  o_last
);
    import glw_pkg::*;

    t_ctl  ctl;
    t_taps taps;
    logic  adv;

    // Grid position, flush sequencing and the edge flags of each stencil.
    glw_ctrl #(
        .WIDTH  (WIDTH),
        .HEIGHT (HEIGHT)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_adv      (adv),
        .o_in_ready (o_in_ready),
        .o_ctl      (ctl)
    );

    // During the flush the buffer shifts in whatever sits on the input; those entries never
    // reach a tap that an emitted stencil uses, and the flush replaces the down tap.
    glw_line_buf #(
        .WIDTH (WIDTH)
    ) u_line_buf (
        .i_clk       (i_clk),
        .i_shift     (ctl.shift),
        .i_potential (i_potential),
        .i_charge    (i_charge),
        .o_taps      (taps)
    );

    // The arriving potential is the down neighbor of the center cell.
    glw_stage u_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_taps       (taps),
        .i_down       (i_potential),
        .i_out_ready  (i_out_ready),
        .o_adv        (adv),
        .o_out_valid  (o_out_valid),
        .o_force_res  (o_force_res),
        .o_cell_index (o_cell_index),
        .o_last       (o_last)
    );

endmodule

@@ hw/rtl/glw_checker.sv @@
// Port-level checks of the stencil block and the bind that attaches them.
// Depends on glw_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module glw_checker #(
    parameter int WIDTH  = 9,
    parameter int HEIGHT = 9
) (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  o_out_valid,
    input logic                                  i_out_ready,
    input logic signed [glw_pkg::FORCE_W-1:0]    o_force_res,
    input logic [glw_pkg::IDX_W-1:0]             o_cell_index,
    input logic                                  o_last
);
    import glw_pkg::*;

    localparam int CELLS = WIDTH * HEIGHT;
    localparam int LW    = $clog2(CELLS) + IDX_W;
    localparam logic [LW-1:0] LAST_WIDE = LW'(CELLS - 1);
    localparam logic [IDX_W-1:0] LAST_IDX = LAST_WIDE[IDX_W-1:0];

    // No result is presented in the cycle after reset.
    `CHK_NEXT_RST(a_reset_clears, !i_rst_n, !o_out_valid)
    // A stalled result stays presented.
    `CHK_NEXT(a_valid_holds, o_out_valid && !i_out_ready, o_out_valid)
    // A stalled result keeps its payload.
    `CHK_NEXT(a_payload_holds, o_out_valid && !i_out_ready,
        $stable(o_force_res) && $stable(o_cell_index) && $stable(o_last))
    // The final-cell flag only appears on the final cell's index.
    `CHK_NOW(a_last_index, o_out_valid && o_last, o_cell_index == LAST_IDX)

endmodule

bind grid_laplacian_weighted glw_checker #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
) u_glw_checker (.*);
